FILE: src/wdq_pkg.sv
// Package for the weight dequantizer: shared types, constants and binary16 helpers.
// No dependencies.
package wdq_pkg;

  localparam int unsigned CbEntries = 16;
  localparam logic [3:0]  CbMask    = 4'hF;
  localparam logic [31:0] QuietNan  = 32'h7FC00000;

  // configuration register indexes (paddr[5:3])
  localparam logic [2:0]  CfgMode   = 3'd0;
  localparam logic [2:0]  CfgCb0    = 3'd1;
  localparam logic [2:0]  CfgCb1    = 3'd2;
  localparam logic [2:0]  CfgCb2    = 3'd3;
  localparam logic [2:0]  CfgCb3    = 3'd4;

  typedef enum logic [2:0] {
    RES_FINITE  = 3'd0,
    RES_ZERO    = 3'd1,
    RES_INF     = 3'd2,
    RES_DEFNAN  = 3'd3,
    RES_DIRECT  = 3'd4
  } res_kind_t;

  // stage-1 output: operands decoded into sign/significand/exponent
  typedef struct packed {
    res_kind_t   kind;
    logic        sign;
    logic [10:0] ma;
    logic [10:0] mb;
    logic [7:0]  ebias;   // e1 + e2 + 127, range 79..137
    logic [31:0] direct;
    logic        last;
  } dec_t;

  // stage-2 output: product computed
  typedef struct packed {
    res_kind_t   kind;
    logic        sign;
    logic [21:0] prod;
    logic [7:0]  ebias;
    logic [31:0] direct;
    logic        last;
  } mul_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        last;
  } res_t;

  function automatic logic [4:0] lead_pos(input logic [21:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 22; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [31:0] pack_single(input logic s, input logic [21:0] m,
                                              input logic [8:0] ebase);
    logic [4:0]  p;
    logic [8:0]  bexp;
    logic [44:0] sh;
    p    = lead_pos(m);
    bexp = ebase + 9'(p);
    sh   = {23'd0, m} << (5'd23 - p);
    return {s, bexp[7:0], sh[22:0]};
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] r;
    if (h[14:10] == 5'h1F) begin
      r = {h[15], 8'hFF, h[9:0], 13'd0};
    end else if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) r = {h[15], 31'd0};
      else r = pack_single(h[15], {12'd0, h[9:0]}, 9'd103);
    end else begin
      r = pack_single(h[15], {11'd0, 1'b1, h[9:0]}, 9'(h[14:10]) + 9'd102);
    end
    return r;
  endfunction

endpackage

FILE: src/wdq_decode.sv
// Stage 1: picks the code operand and classifies both operands.
// Depends on wdq_pkg.
module wdq_decode (
  input  logic              mode,
  input  logic [255:0]      codebook,
  input  logic [7:0]        quant_code,
  input  logic [15:0]       scale_half,
  input  logic              is_outlier,
  input  logic [15:0]       outlier_half,
  input  logic              last_weight,
  output wdq_pkg::dec_t     dec
);
  import wdq_pkg::*;

  logic [3:0]  idx;
  logic [15:0] entry;
  logic        a_s, a_inf, a_nan, b_s, b_inf, b_nan;
  logic [10:0] ma, mb;
  logic [5:0]  ea, eb;   // exponent + 24, per operand

  always_comb begin
    idx   = quant_code[3:0] & CbMask;
    entry = codebook[{idx, 4'd0} +: 16];
    a_inf = 1'b0;
    a_nan = 1'b0;
    if (!mode) begin
      a_s = quant_code[7];
      ma  = a_s ? 11'(9'd256 - {1'b0, quant_code}) : {3'd0, quant_code};
      ea  = 6'd24;
    end else begin
      a_s   = entry[15];
      a_nan = entry[14:10] == 5'h1F && entry[9:0] != '0;
      a_inf = entry[14:10] == 5'h1F && entry[9:0] == '0;
      ma    = (entry[14:10] == 5'd0) ? {1'b0, entry[9:0]} : {1'b1, entry[9:0]};
      ea    = (entry[14:10] == 5'd0) ? 6'd0 : 6'(entry[14:10]) - 6'd1;
    end
    b_s   = scale_half[15];
    b_nan = scale_half[14:10] == 5'h1F && scale_half[9:0] != '0;
    b_inf = scale_half[14:10] == 5'h1F && scale_half[9:0] == '0;
    mb    = (scale_half[14:10] == 5'd0) ? {1'b0, scale_half[9:0]}
                                        : {1'b1, scale_half[9:0]};
    eb    = (scale_half[14:10] == 5'd0) ? 6'd0 : 6'(scale_half[14:10]) - 6'd1;

    dec.sign   = a_s ^ b_s;
    dec.ma     = ma;
    dec.mb     = mb;
    // biased exponent base: e1 + e2 + 127 = ea + eb - 48 + 127
    dec.ebias  = {2'd0, ea} + {2'd0, eb} + 8'd79;
    dec.last   = last_weight;
    dec.direct = '0;
    if (is_outlier) begin
      dec.kind   = RES_DIRECT;
      dec.direct = widen_half(outlier_half);
    end else if (a_nan) begin
      dec.kind   = RES_DIRECT;
      dec.direct = widen_half(entry) | 32'h00400000;
    end else if (b_nan) begin
      dec.kind   = RES_DIRECT;
      dec.direct = widen_half(scale_half) | 32'h00400000;
    end else if (a_inf || b_inf) begin
      if ((!a_inf && ma == '0) || (!b_inf && mb == '0)) dec.kind = RES_DEFNAN;
      else dec.kind = RES_INF;
    end else if (ma == '0 || mb == '0) begin
      dec.kind = RES_ZERO;
    end else begin
      dec.kind = RES_FINITE;
    end
  end
endmodule

FILE: src/wdq_pack.sv
// Final stage logic: normalizes the exact product into binary32 bits, or emits zero, infinity, NaN or the direct value.
// Depends on wdq_pkg.
module wdq_pack (
  input  wdq_pkg::mul_t mul,
  output wdq_pkg::res_t res
);
  import wdq_pkg::*;

  always_comb begin
    res.last = mul.last;
    case (mul.kind)
      RES_FINITE: res.weight = pack_single(mul.sign, mul.prod, {1'b0, mul.ebias});
      RES_ZERO:   res.weight = {mul.sign, 31'd0};
      RES_INF:    res.weight = {mul.sign, 8'hFF, 23'd0};
      RES_DEFNAN: res.weight = QuietNan;
      RES_DIRECT: res.weight = mul.direct;
      default:    res.weight = QuietNan;
    endcase
  end
endmodule

FILE: src/weight_dequant_int8_or_codebook_unit.sv
// Weight dequantizer, int8 or 16-entry codebook times binary16 scale, binary32 out.
// Throughput 1 item per cycle while a valid output is not held by out_stall.
// Three register stages (decode, multiply, pack) advance together whenever the
// output stage is free or being taken; stall holds every stage.
// Reset (synchronous, rst_n low) clears stage valids, mode and codebook registers.
module weight_dequant_int8_or_codebook_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_quant_code,
  input  logic [15:0] in_scale_half,
  input  logic        in_is_outlier,
  input  logic [15:0] in_outlier_half,
  input  logic        in_last_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_weight_single,
  output logic        out_last_weight_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import wdq_pkg::*;

  logic         mode_r;
  logic [255:0] cb_r;
  dec_t         dec, s1_r;
  mul_t         s2_r;
  res_t         res, s3_r;
  logic         v1_r, v2_r, v3_r, adv;
  logic [2:0]   ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cb_r   <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        CfgMode: mode_r <= pwdata[0];
        CfgCb0:  cb_r[63:0]    <= pwdata;
        CfgCb1:  cb_r[127:64]  <= pwdata;
        CfgCb2:  cb_r[191:128] <= pwdata;
        CfgCb3:  cb_r[255:192] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      CfgMode: prdata = {63'd0, mode_r};
      CfgCb0:  prdata = cb_r[63:0];
      CfgCb1:  prdata = cb_r[127:64];
      CfgCb2:  prdata = cb_r[191:128];
      CfgCb3:  prdata = cb_r[255:192];
      default: prdata = '0;
    endcase
  end

  // whole pipe moves together; a free output slot lets bubbles collapse too
  assign adv      = !(v3_r && out_stall);
  assign in_stall = !adv;

  wdq_decode u_dec (
    .mode(mode_r), .codebook(cb_r), .quant_code(in_quant_code),
    .scale_half(in_scale_half), .is_outlier(in_is_outlier),
    .outlier_half(in_outlier_half), .last_weight(in_last_weight), .dec(dec)
  );

  wdq_pack u_pack (.mul(s2_r), .res(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r        <= dec;
      s2_r.kind   <= s1_r.kind;
      s2_r.sign   <= s1_r.sign;
      s2_r.prod   <= {11'd0, s1_r.ma} * {11'd0, s1_r.mb};
      s2_r.ebias  <= s1_r.ebias;
      s2_r.direct <= s1_r.direct;
      s2_r.last   <= s1_r.last;
      s3_r        <= res;
    end
  end

  assign out_valid           = v3_r;
  assign out_weight_single   = s3_r.weight;
  assign out_last_weight_out = s3_r.last;
endmodule

FILE: src/wdq_checker.sv
// Port-level checker for the weight dequantizer, bound to the top level.
// Depends on weight_dequant_int8_or_codebook_unit ports only.
module wdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_weight_single,
  input logic        pready
);
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight_single))
    else $error("stalled result changed");
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
    else $error("accepted transaction lost");
endmodule

bind weight_dequant_int8_or_codebook_unit wdq_checker u_wdq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_weight_single(out_weight_single), .pready(pready)
);
